/* rtl/core/hnu_pkg.sv */
package hnu_pkg;

   // Input heights: two's complement, 8 fraction bits.
   localparam int HEIGHT_BITS = 16;
   // Height differences need one extra bit so that they never wrap.
   localparam int DIFF_BITS = HEIGHT_BITS + 1;
   // Magnitudes are kept at least 10 bits wide so that the remainder width below
   // also covers the constant up component.
   localparam int MAG_BITS = (HEIGHT_BITS > 10) ? HEIGHT_BITS : 10;
   localparam int SQ_BITS = 2 * MAG_BITS;
   localparam int SUM_BITS = SQ_BITS + 2;

   // Result format: signed Q1.14.
   localparam int FRAC_BITS = 14;
   localparam int OUT_BITS = 16;
   localparam int NUM_BITS = FRAC_BITS + 1;
   localparam int ROOT_STAGES = NUM_BITS;
   localparam int UNIT_ONE = 1 << FRAC_BITS;

   // The squared magnitude is scaled by 2^30 before it is compared with
   // (2n-1)^2 * S.
   localparam int TARGET_SHIFT = 2 * FRAC_BITS + 2;
   localparam int PROD_BITS = SUM_BITS + NUM_BITS + 1;
   localparam int REM_BITS = SQ_BITS + 2 * FRAC_BITS + 8;

   // The halved up component is 2.0 with 8 fraction bits.
   localparam int HALF_UP = 512;
   localparam logic [SUM_BITS-1:0] UP_SQ = SUM_BITS'(HALF_UP * HALF_UP);

   localparam int LANES = 3;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   // One component while its magnitude is being resolved. rem holds
   // M - t^2 * S and prod holds t * S, where t = 2 * num - 1.
   typedef struct packed {
      logic                        neg;
      logic signed [REM_BITS-1:0]  rem;
      logic signed [PROD_BITS-1:0] prod;
      logic [NUM_BITS-1:0]         num;
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0]  lane;
      logic [SUM_BITS-1:0]   sum;
   } root_type;

endpackage

/* rtl/core/hnu_prep.sv */
module hnu_prep (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [hnu_pkg::HEIGHT_BITS-1:0] height_left,
   input  logic signed [hnu_pkg::HEIGHT_BITS-1:0] height_right,
   input  logic signed [hnu_pkg::HEIGHT_BITS-1:0] height_top,
   input  logic signed [hnu_pkg::HEIGHT_BITS-1:0] height_bottom,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output hnu_pkg::root_type                      out_data
);

   typedef struct packed {
      logic                         neg_x;
      logic [hnu_pkg::MAG_BITS-1:0] mag_x;
      logic                         neg_z;
      logic [hnu_pkg::MAG_BITS-1:0] mag_z;
   } diff_type;

   typedef struct packed {
      logic                        neg_x;
      logic [hnu_pkg::SQ_BITS-1:0] sq_x;
      logic                        neg_z;
      logic [hnu_pkg::SQ_BITS-1:0] sq_z;
   } square_type;

   function automatic logic [hnu_pkg::MAG_BITS-1:0] magnitude(
      input logic signed [hnu_pkg::DIFF_BITS-1:0] value
   );
      logic signed [hnu_pkg::DIFF_BITS-1:0] pos;
      pos = value[hnu_pkg::DIFF_BITS-1] ? -value : value;
      return hnu_pkg::MAG_BITS'($unsigned(pos));
   endfunction

   logic [2:0]                           valid_ff;
   logic [2:0]                           valid_in;
   logic [2:0]                           stage_ready;
   logic signed [hnu_pkg::DIFF_BITS-1:0] diff_x;
   logic signed [hnu_pkg::DIFF_BITS-1:0] diff_z;
   logic [hnu_pkg::SUM_BITS-1:0]         sum;
   diff_type                             s1_ff;
   diff_type                             s1_in;
   square_type                           s2_ff;
   square_type                           s2_in;
   hnu_pkg::root_type                    s3_ff;
   hnu_pkg::root_type                    s3_in;

   // A stage takes a new word when it is empty or when its word moves on.
   assign stage_ready[2] = !valid_ff[2] || out_ready;
   assign stage_ready[1] = !valid_ff[1] || stage_ready[2];
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];
   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= valid_in[0];
         end
         if (stage_ready[1]) begin
            valid_ff[1] <= valid_in[1];
         end
         if (stage_ready[2]) begin
            valid_ff[2] <= valid_in[2];
         end
      end
   end

   // Halved cross product: X = left - right, Z = bottom - top.
   always_comb begin
      diff_x = hnu_pkg::DIFF_BITS'(height_left) - hnu_pkg::DIFF_BITS'(height_right);
      diff_z = hnu_pkg::DIFF_BITS'(height_bottom) - hnu_pkg::DIFF_BITS'(height_top);
      s1_in.neg_x = diff_x[hnu_pkg::DIFF_BITS-1];
      s1_in.mag_x = magnitude(diff_x);
      s1_in.neg_z = diff_z[hnu_pkg::DIFF_BITS-1];
      s1_in.mag_z = magnitude(diff_z);
   end

   always_comb begin
      s2_in.neg_x = s1_ff.neg_x;
      s2_in.sq_x  = hnu_pkg::SQ_BITS'(s1_ff.mag_x) * hnu_pkg::SQ_BITS'(s1_ff.mag_x);
      s2_in.neg_z = s1_ff.neg_z;
      s2_in.sq_z  = hnu_pkg::SQ_BITS'(s1_ff.mag_z) * hnu_pkg::SQ_BITS'(s1_ff.mag_z);
   end

   // Seed each lane with t = -1, so rem = M - S and prod = -S.
   always_comb begin
      sum = hnu_pkg::SUM_BITS'(s2_ff.sq_x) + hnu_pkg::SUM_BITS'(s2_ff.sq_z) + hnu_pkg::UP_SQ;
      s3_in.sum = sum;

      s3_in.lane[hnu_pkg::LANE_X].neg  = s2_ff.neg_x;
      s3_in.lane[hnu_pkg::LANE_X].rem  =
         (hnu_pkg::REM_BITS'(s2_ff.sq_x) << hnu_pkg::TARGET_SHIFT) - hnu_pkg::REM_BITS'(sum);
      s3_in.lane[hnu_pkg::LANE_X].prod = -hnu_pkg::PROD_BITS'(sum);
      s3_in.lane[hnu_pkg::LANE_X].num  = '0;

      s3_in.lane[hnu_pkg::LANE_Y].neg  = 1'b0;
      s3_in.lane[hnu_pkg::LANE_Y].rem  =
         (hnu_pkg::REM_BITS'(hnu_pkg::UP_SQ) << hnu_pkg::TARGET_SHIFT) -
         hnu_pkg::REM_BITS'(sum);
      s3_in.lane[hnu_pkg::LANE_Y].prod = -hnu_pkg::PROD_BITS'(sum);
      s3_in.lane[hnu_pkg::LANE_Y].num  = '0;

      s3_in.lane[hnu_pkg::LANE_Z].neg  = s2_ff.neg_z;
      s3_in.lane[hnu_pkg::LANE_Z].rem  =
         (hnu_pkg::REM_BITS'(s2_ff.sq_z) << hnu_pkg::TARGET_SHIFT) - hnu_pkg::REM_BITS'(sum);
      s3_in.lane[hnu_pkg::LANE_Z].prod = -hnu_pkg::PROD_BITS'(sum);
      s3_in.lane[hnu_pkg::LANE_Z].num  = '0;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         s1_ff <= s1_in;
      end
      if (stage_ready[1]) begin
         s2_ff <= s2_in;
      end
      if (stage_ready[2]) begin
         s3_ff <= s3_in;
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[2];
   assign out_data  = s3_ff;

   // The squared length always includes the up component and must not wrap.
   a_sum_floor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (s3_ff.sum >= hnu_pkg::UP_SQ))
      else $error("squared length below the up component");

endmodule

/* rtl/core/hnu_root.sv */
module hnu_root (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hnu_pkg::root_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output hnu_pkg::root_type out_data
);

   localparam int LAST = hnu_pkg::ROOT_STAGES - 1;

   // Try setting bit pos of num: t grows by 2^(pos+1), so
   // t'^2 * S = t^2 * S + 2^(pos+2) * t * S + 2^(2pos+2) * S.
   function automatic hnu_pkg::lane_type lane_step(
      input hnu_pkg::lane_type             cur,
      input logic [hnu_pkg::SUM_BITS-1:0]  sum,
      input int unsigned                   pos
   );
      logic signed [hnu_pkg::REM_BITS-1:0] prod_ext;
      logic signed [hnu_pkg::REM_BITS-1:0] sum_ext;
      logic signed [hnu_pkg::REM_BITS-1:0] trial;
      hnu_pkg::lane_type                   nxt;
      prod_ext = hnu_pkg::REM_BITS'(cur.prod);
      sum_ext  = hnu_pkg::REM_BITS'(sum);
      trial    = cur.rem - (prod_ext <<< (pos + 2)) - (sum_ext <<< (2 * pos + 2));
      nxt      = cur;
      if (!trial[hnu_pkg::REM_BITS-1]) begin
         nxt.rem  = trial;
         nxt.prod = cur.prod + (hnu_pkg::PROD_BITS'(sum) << (pos + 1));
         nxt.num  = cur.num | (hnu_pkg::NUM_BITS'(1) << pos);
      end
      return nxt;
   endfunction

   function automatic hnu_pkg::root_type root_step(
      input hnu_pkg::root_type cur,
      input int unsigned       pos
   );
      hnu_pkg::root_type nxt;
      nxt = cur;
      nxt.lane[hnu_pkg::LANE_X] = lane_step(cur.lane[hnu_pkg::LANE_X], cur.sum, pos);
      nxt.lane[hnu_pkg::LANE_Y] = lane_step(cur.lane[hnu_pkg::LANE_Y], cur.sum, pos);
      nxt.lane[hnu_pkg::LANE_Z] = lane_step(cur.lane[hnu_pkg::LANE_Z], cur.sum, pos);
      return nxt;
   endfunction

   logic [hnu_pkg::ROOT_STAGES-1:0] valid_ff;
   logic [hnu_pkg::ROOT_STAGES-1:0] valid_in;
   logic [hnu_pkg::ROOT_STAGES-1:0] stage_ready;
   hnu_pkg::root_type               stage_ff [hnu_pkg::ROOT_STAGES];
   hnu_pkg::root_type               stage_in [hnu_pkg::ROOT_STAGES];

   assign valid_in = {valid_ff[hnu_pkg::ROOT_STAGES-2:0], in_valid};

   // One stage per result bit, most significant first.
   for (genvar k = 0; k < hnu_pkg::ROOT_STAGES; k++) begin : g_stage
      localparam int POS = hnu_pkg::NUM_BITS - 1 - k;

      if (k == 0) begin : g_first
         assign stage_in[k] = root_step(in_data, POS);
      end else begin : g_next
         assign stage_in[k] = root_step(stage_ff[k-1], POS);
      end

      if (k == LAST) begin : g_tail
         assign stage_ready[k] = !valid_ff[k] || out_ready;
      end else begin : g_body
         assign stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stage_ready[k]) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_data  = stage_ff[LAST];

   // Once a lane has a nonzero result, its last accepted trial left a
   // nonnegative remainder.
   a_rem_sign: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] |->
         ((stage_ff[LAST].lane[hnu_pkg::LANE_X].num == '0) ||
          !stage_ff[LAST].lane[hnu_pkg::LANE_X].rem[hnu_pkg::REM_BITS-1]) &&
         ((stage_ff[LAST].lane[hnu_pkg::LANE_Y].num == '0) ||
          !stage_ff[LAST].lane[hnu_pkg::LANE_Y].rem[hnu_pkg::REM_BITS-1]) &&
         ((stage_ff[LAST].lane[hnu_pkg::LANE_Z].num == '0) ||
          !stage_ff[LAST].lane[hnu_pkg::LANE_Z].rem[hnu_pkg::REM_BITS-1]))
      else $error("negative remainder behind a nonzero component");

endmodule

/* rtl/core/heightmap_normal_unit.sv */
// An accepted request word passes 19 register stages in order (3 preparation stages, 15 root
// stages, one output register) before it shows on rsp_valid. Throughput: one word per cycle
// while rsp_ready is high, as each stage takes a new word when empty or when its word moves on.
// Empty stages close up while the response side stalls, so requests keep entering.
// Reset: synchronous, active high; it clears only the stage valid bits, not the data.
module heightmap_normal_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [hnu_pkg::HEIGHT_BITS-1:0] req_height_left,
   input  logic signed [hnu_pkg::HEIGHT_BITS-1:0] req_height_right,
   input  logic signed [hnu_pkg::HEIGHT_BITS-1:0] req_height_top,
   input  logic signed [hnu_pkg::HEIGHT_BITS-1:0] req_height_bottom,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [hnu_pkg::OUT_BITS-1:0]    rsp_normal_x,
   output logic signed [hnu_pkg::OUT_BITS-1:0]    rsp_normal_y,
   output logic signed [hnu_pkg::OUT_BITS-1:0]    rsp_normal_z
);

   // A unit vector in Q1.14 squares to 2^28. Each component is off by at most
   // half an LSB, which moves the sum of squares by well under 2^16.
   localparam int NORM_SQ  = hnu_pkg::UNIT_ONE * hnu_pkg::UNIT_ONE;
   localparam int NORM_TOL = 1 << 16;

   // The magnitude comes out of the root stages unsigned; the sign of the
   // original difference is put back here.
   function automatic logic signed [hnu_pkg::OUT_BITS-1:0] signed_out(
      input hnu_pkg::lane_type lane
   );
      logic signed [hnu_pkg::OUT_BITS-1:0] mag;
      mag = hnu_pkg::OUT_BITS'(lane.num);
      return lane.neg ? -mag : mag;
   endfunction

   logic                                prep_valid;
   logic                                prep_ready;
   hnu_pkg::root_type                   prep_data;
   logic                                root_valid;
   logic                                root_ready;
   hnu_pkg::root_type                   root_data;
   logic                                rsp_valid_ff;
   logic signed [hnu_pkg::OUT_BITS-1:0] normal_x_ff;
   logic signed [hnu_pkg::OUT_BITS-1:0] normal_y_ff;
   logic signed [hnu_pkg::OUT_BITS-1:0] normal_z_ff;
   logic signed [hnu_pkg::OUT_BITS-1:0] normal_x_in;
   logic signed [hnu_pkg::OUT_BITS-1:0] normal_y_in;
   logic signed [hnu_pkg::OUT_BITS-1:0] normal_z_in;

   // Front end: height differences, their squares, and the squared length
   // S = X^2 + 512^2 + Z^2. It also seeds the three lanes of the root.
   hnu_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .height_left   (req_height_left),
      .height_right  (req_height_right),
      .height_top    (req_height_top),
      .height_bottom (req_height_bottom),
      .out_valid     (prep_valid),
      .out_ready     (prep_ready),
      .out_data      (prep_data)
   );

   // Root stages: for each component, the largest n with
   // (2n-1)^2 * S <= |c|^2 * 2^30 is found one bit per stage. That n is
   // |c| * 2^14 / sqrt(S) rounded to nearest, with halves rounded away from zero.
   hnu_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_data  (root_data)
   );

   // Output register. It reloads when empty or when its word is taken, so a
   // waiting word never blocks the stages behind it for longer than needed.
   assign root_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      normal_x_in = signed_out(root_data.lane[hnu_pkg::LANE_X]);
      normal_y_in = signed_out(root_data.lane[hnu_pkg::LANE_Y]);
      normal_z_in = signed_out(root_data.lane[hnu_pkg::LANE_Z]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (root_ready) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (root_ready) begin
         normal_x_ff <= normal_x_in;
         normal_y_ff <= normal_y_in;
         normal_z_ff <= normal_z_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_normal_x = normal_x_ff;
   assign rsp_normal_y = normal_y_ff;
   assign rsp_normal_z = normal_z_ff;

   // The up component is never negative and never above 1.0.
   a_up_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_normal_y[hnu_pkg::OUT_BITS-1] &&
                     (rsp_normal_y <= hnu_pkg::UNIT_ONE)))
      else $error("up component out of range");

   // The side components stay within plus or minus 1.0.
   a_side_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_normal_x <= hnu_pkg::UNIT_ONE) &&
                     (rsp_normal_x >= -hnu_pkg::UNIT_ONE) &&
                     (rsp_normal_z <= hnu_pkg::UNIT_ONE) &&
                     (rsp_normal_z >= -hnu_pkg::UNIT_ONE)))
      else $error("side component out of range");

   // All three lanes belong to the same word and make a unit vector together.
   a_unit_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((32'(rsp_normal_x) * 32'(rsp_normal_x) + 32'(rsp_normal_y) * 32'(rsp_normal_y) +
           32'(rsp_normal_z) * 32'(rsp_normal_z) >= NORM_SQ - NORM_TOL) &&
          (32'(rsp_normal_x) * 32'(rsp_normal_x) + 32'(rsp_normal_y) * 32'(rsp_normal_y) +
           32'(rsp_normal_z) * 32'(rsp_normal_z) <= NORM_SQ + NORM_TOL)))
      else $error("normal is not of unit length");

endmodule
